### sv/wpsp_pkg.sv
// ----------------------------------------------------------------------------
// wpsp_pkg
// Shared types and constants for the WAV PCM16 stream parser.
// ----------------------------------------------------------------------------
package wpsp_pkg;

   localparam logic [31:0] RIFF_WORD   = 32'h4646_4952;
   localparam logic [31:0] WAVE_WORD   = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT     = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA    = 32'h6174_6164;
   localparam logic [31:0] LEN_ENDLESS = 32'hFFFF_FFFF;
   localparam logic [31:0] FMT_BYTES   = 32'd16;
   localparam logic [5:0]  MIN_FILE    = 6'd44;
   localparam logic [15:0] PCM_BITS    = 16'd16;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_BAD_HEADER = 2'd1,
      STATUS_BAD_FORMAT = 2'd2,
      STATUS_NO_DATA    = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic               sample_valid;
      logic signed [15:0] sample;
      logic               channel_index;
      logic               done_res;
      status_type         status;
      logic [30:0]        sample_rate;
      logic [1:0]         channel_count;
   } rsp_type;

endpackage

### sv/wav_pcm16_stream_parser_unit.sv
// ----------------------------------------------------------------------------
// wav_pcm16_stream_parser_unit
// RIFF/WAVE parser that turns a byte stream into 16-bit PCM samples.
// ----------------------------------------------------------------------------
// Request channel (req_valid / req_stall / req): one byte of the file per
// request, with last_byte set on the final byte of the file.
// Response channel (rsp_valid / rsp_stall / rsp): one response for each
// request that completes a sample pair of the data chunk while the format
// is valid, and one for the final byte, which carries done_res and the
// status. Both may share one response.
// Throughput: one byte per cycle while the queue is not full; every byte
// updates the parser registers as it is accepted. A response passes through
// the parser-to-output queue and then the output register before it appears.
// When the receiver stalls, the queue fills; once it is full req_stall rises
// and the parser holds. After the final byte the parser returns to its
// reset state and the next byte starts a new file.
// Reset clears the parser, empties the queue and drops any pending response.
// ----------------------------------------------------------------------------
module wav_pcm16_stream_parser_unit #(
   parameter int QUEUE_DEPTH = wpsp_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  wpsp_pkg::req_type req,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output wpsp_pkg::rsp_type rsp
);

   logic              queue_full;
   logic              push_valid;
   wpsp_pkg::rsp_type push_data;
   logic              pop_valid;
   logic              pop_ready;
   wpsp_pkg::rsp_type pop_data;

   wpsp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req        (req),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   wpsp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   wpsp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp.done_res |-> rsp.sample_valid)
      else $error("response carries neither a sample nor a done mark");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp.done_res |-> rsp.status == wpsp_pkg::STATUS_OK)
      else $error("status reported on a response that is not the last");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp.sample_valid |-> rsp.sample == 16'sd0 && !rsp.channel_index)
      else $error("sample fields set without a sample");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response pending right after reset");

endmodule

### sv/wpsp_front.sv
// ----------------------------------------------------------------------------
// wpsp_front
// Header check, chunk walk, fmt capture and sample assembly, one byte a cycle while the queue has room.
// ----------------------------------------------------------------------------
module wpsp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  wpsp_pkg::req_type req,
   input  logic              queue_full,
   output logic              push_valid,
   output wpsp_pkg::rsp_type push_data
);

   typedef enum logic [5:0] {
      PH_HEADER = 6'b000001,
      PH_CHUNK  = 6'b000010,
      PH_FMT    = 6'b000100,
      PH_SKIP   = 6'b001000,
      PH_DATA   = 6'b010000,
      PH_STOP   = 6'b100000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [5:0]  bytes_seen_ff, bytes_seen_in;
   logic [31:0] chunk_tag_ff, chunk_tag_in;
   logic [31:0] chunk_length_ff, chunk_length_in;
   logic [31:0] skip_remaining_ff, skip_remaining_in;
   logic [3:0]  format_window_ff, format_window_in;
   logic [15:0] format_channels_ff, format_channels_in;
   logic [31:0] format_rate_ff, format_rate_in;
   logic [15:0] format_bits_ff, format_bits_in;
   logic [31:0] data_remaining_ff, data_remaining_in;
   logic [7:0]  low_byte_hold_ff, low_byte_hold_in;
   logic        byte_parity_ff, byte_parity_in;
   logic        channel_toggle_ff, channel_toggle_in;
   logic        bad_header_ff, bad_header_in;
   logic        data_found_ff, data_found_in;
   logic        pair_seen_ff, pair_seen_in;
   logic        endless_ff, endless_in;

   logic        accept;
   logic        emit;
   logic [15:0] sample_value;
   logic        sample_channel;
   logic [31:0] size_value;
   logic [7:0]  in_byte;
   logic        format_ok_now;
   logic        format_ok_next;
   wpsp_pkg::status_type status_value;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign in_byte   = req.byte_value;

   assign format_ok_now = (format_channels_ff == 16'd1 || format_channels_ff == 16'd2) &&
                          (format_rate_ff != 32'd0) && !format_rate_ff[31] &&
                          (format_bits_ff == wpsp_pkg::PCM_BITS);

   always_comb begin
      phase_in           = phase_ff;
      bytes_seen_in      = bytes_seen_ff;
      chunk_tag_in       = chunk_tag_ff;
      chunk_length_in    = chunk_length_ff;
      skip_remaining_in  = skip_remaining_ff;
      format_window_in   = format_window_ff;
      format_channels_in = format_channels_ff;
      format_rate_in     = format_rate_ff;
      format_bits_in     = format_bits_ff;
      data_remaining_in  = data_remaining_ff;
      low_byte_hold_in   = low_byte_hold_ff;
      byte_parity_in     = byte_parity_ff;
      channel_toggle_in  = channel_toggle_ff;
      bad_header_in      = bad_header_ff;
      data_found_in      = data_found_ff;
      pair_seen_in       = pair_seen_ff;
      endless_in         = endless_ff;
      emit               = 1'b0;
      sample_value       = 16'd0;
      sample_channel     = 1'b0;
      size_value         = 32'd0;
      format_ok_next     = 1'b0;
      status_value       = wpsp_pkg::STATUS_OK;

      if (accept) begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (bytes_seen_ff < 6'd4 &&
                   in_byte != wpsp_pkg::RIFF_WORD[{bytes_seen_ff[1:0], 3'b000} +: 8]) begin
                  bad_header_in = 1'b1;
               end
               if (bytes_seen_ff >= 6'd8 && bytes_seen_ff < 6'd12 &&
                   in_byte != wpsp_pkg::WAVE_WORD[{bytes_seen_ff[1:0], 3'b000} +: 8]) begin
                  bad_header_in = 1'b1;
               end
               if (bytes_seen_ff >= 6'd11) begin
                  phase_in         = bad_header_in ? PH_STOP : PH_CHUNK;
                  format_window_in = 4'd0;
               end
            end
            PH_CHUNK: begin
               if (!format_window_ff[2]) begin
                  chunk_tag_in[{format_window_ff[1:0], 3'b000} +: 8] = in_byte;
               end else begin
                  chunk_length_in[{format_window_ff[1:0], 3'b000} +: 8] = in_byte;
               end
               if (format_window_ff[2:0] == 3'd7) begin
                  size_value       = chunk_length_in;
                  format_window_in = 4'd0;
                  if (chunk_tag_ff == wpsp_pkg::TAG_DATA) begin
                     data_found_in     = 1'b1;
                     data_remaining_in = size_value;
                     byte_parity_in    = 1'b0;
                     channel_toggle_in = 1'b0;
                     phase_in          = (size_value != 32'd0) ? PH_DATA : PH_STOP;
                  end else if (chunk_tag_ff == wpsp_pkg::TAG_FMT &&
                               size_value >= wpsp_pkg::FMT_BYTES) begin
                     phase_in = PH_FMT;
                     if (size_value == wpsp_pkg::LEN_ENDLESS) begin
                        endless_in        = 1'b1;
                        skip_remaining_in = 32'd0;
                     end else begin
                        skip_remaining_in = size_value -
                                            (size_value[0] ? 32'd15 : 32'd16);
                     end
                     chunk_tag_in    = 32'd0;
                     chunk_length_in = 32'd0;
                  end else if (size_value == wpsp_pkg::LEN_ENDLESS) begin
                     phase_in = PH_STOP;
                  end else begin
                     skip_remaining_in = size_value + {31'd0, size_value[0]};
                     phase_in          = (size_value != 32'd0) ? PH_SKIP : PH_CHUNK;
                  end
               end else begin
                  format_window_in = {1'b0, format_window_ff[2:0] + 3'd1};
               end
            end
            PH_FMT: begin
               case (format_window_ff) inside
                  4'd2, 4'd3: begin
                     chunk_tag_in[{1'b0, format_window_ff[0], 3'b000} +: 8] = in_byte;
                  end
                  [4'd4:4'd7]: begin
                     chunk_length_in[{format_window_ff[1:0], 3'b000} +: 8] = in_byte;
                  end
                  4'd14, 4'd15: begin
                     chunk_tag_in[{1'b1, format_window_ff[0], 3'b000} +: 8] = in_byte;
                  end
                  default: begin
                  end
               endcase
               if (format_window_ff == 4'd15) begin
                  format_channels_in = chunk_tag_in[15:0];
                  format_bits_in     = chunk_tag_in[31:16];
                  format_rate_in     = chunk_length_in;
                  format_window_in   = 4'd0;
                  if (endless_ff) begin
                     phase_in = PH_STOP;
                  end else begin
                     phase_in = (skip_remaining_ff != 32'd0) ? PH_SKIP : PH_CHUNK;
                  end
               end else begin
                  format_window_in = format_window_ff + 4'd1;
               end
            end
            PH_SKIP: begin
               skip_remaining_in = skip_remaining_ff - 32'd1;
               if (skip_remaining_ff == 32'd1) begin
                  phase_in         = PH_CHUNK;
                  format_window_in = 4'd0;
               end
            end
            PH_DATA: begin
               if (!byte_parity_ff) begin
                  low_byte_hold_in = in_byte;
                  byte_parity_in   = 1'b1;
               end else begin
                  byte_parity_in = 1'b0;
                  pair_seen_in   = 1'b1;
                  if (format_ok_now) begin
                     emit           = 1'b1;
                     sample_value   = {in_byte, low_byte_hold_ff};
                     sample_channel = channel_toggle_ff;
                  end
                  if (format_channels_ff == 16'd2) begin
                     channel_toggle_in = !channel_toggle_ff;
                  end
               end
               data_remaining_in = data_remaining_ff - 32'd1;
               if (data_remaining_ff == 32'd1) begin
                  phase_in = PH_STOP;
               end
            end
            PH_STOP: begin
            end
            default: begin
            end
         endcase

         if (bytes_seen_ff < wpsp_pkg::MIN_FILE) begin
            bytes_seen_in = bytes_seen_ff + 6'd1;
         end
      end

      format_ok_next = (format_channels_in == 16'd1 || format_channels_in == 16'd2) &&
                       (format_rate_in != 32'd0) && !format_rate_in[31] &&
                       (format_bits_in == wpsp_pkg::PCM_BITS);

      if (req.last_byte) begin
         if (bytes_seen_in < wpsp_pkg::MIN_FILE || bad_header_in) begin
            status_value = wpsp_pkg::STATUS_BAD_HEADER;
         end else if (!format_ok_next) begin
            status_value = wpsp_pkg::STATUS_BAD_FORMAT;
         end else if (!data_found_in || !pair_seen_in) begin
            status_value = wpsp_pkg::STATUS_NO_DATA;
         end
      end

      push_valid              = accept && (emit || req.last_byte);
      push_data.sample_valid  = emit;
      push_data.sample        = sample_value;
      push_data.channel_index = sample_channel;
      push_data.done_res      = req.last_byte;
      push_data.status        = status_value;
      push_data.sample_rate   = format_rate_in[31] ? 31'd0 : format_rate_in[30:0];
      push_data.channel_count = (format_channels_in == 16'd1 || format_channels_in == 16'd2)
                                ? format_channels_in[1:0] : 2'd0;

      // start over for the next file
      if (accept && req.last_byte) begin
         phase_in           = PH_HEADER;
         bytes_seen_in      = 6'd0;
         chunk_tag_in       = 32'd0;
         chunk_length_in    = 32'd0;
         skip_remaining_in  = 32'd0;
         format_window_in   = 4'd0;
         format_channels_in = 16'd0;
         format_rate_in     = 32'd0;
         format_bits_in     = 16'd0;
         data_remaining_in  = 32'd0;
         low_byte_hold_in   = 8'd0;
         byte_parity_in     = 1'b0;
         channel_toggle_in  = 1'b0;
         bad_header_in      = 1'b0;
         data_found_in      = 1'b0;
         pair_seen_in       = 1'b0;
         endless_in         = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_HEADER;
         bytes_seen_ff      <= 6'd0;
         chunk_tag_ff       <= 32'd0;
         chunk_length_ff    <= 32'd0;
         skip_remaining_ff  <= 32'd0;
         format_window_ff   <= 4'd0;
         format_channels_ff <= 16'd0;
         format_rate_ff     <= 32'd0;
         format_bits_ff     <= 16'd0;
         data_remaining_ff  <= 32'd0;
         low_byte_hold_ff   <= 8'd0;
         byte_parity_ff     <= 1'b0;
         channel_toggle_ff  <= 1'b0;
         bad_header_ff      <= 1'b0;
         data_found_ff      <= 1'b0;
         pair_seen_ff       <= 1'b0;
         endless_ff         <= 1'b0;
      end else begin
         phase_ff           <= phase_in;
         bytes_seen_ff      <= bytes_seen_in;
         chunk_tag_ff       <= chunk_tag_in;
         chunk_length_ff    <= chunk_length_in;
         skip_remaining_ff  <= skip_remaining_in;
         format_window_ff   <= format_window_in;
         format_channels_ff <= format_channels_in;
         format_rate_ff     <= format_rate_in;
         format_bits_ff     <= format_bits_in;
         data_remaining_ff  <= data_remaining_in;
         low_byte_hold_ff   <= low_byte_hold_in;
         byte_parity_ff     <= byte_parity_in;
         channel_toggle_ff  <= channel_toggle_in;
         bad_header_ff      <= bad_header_in;
         data_found_ff      <= data_found_in;
         pair_seen_ff       <= pair_seen_in;
         endless_ff         <= endless_in;
      end
   end

endmodule

### sv/wpsp_queue.sv
// ----------------------------------------------------------------------------
// wpsp_queue
// Small result queue between the parser front and the output stage.
// ----------------------------------------------------------------------------
module wpsp_queue #(
   parameter int DEPTH = wpsp_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  wpsp_pkg::rsp_type push_data,
   output logic              full,
   output logic              pop_valid,
   input  logic              pop_ready,
   output wpsp_pkg::rsp_type pop_data
);

   localparam int PtrWidth   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CountWidth = $clog2(DEPTH + 1);

   wpsp_pkg::rsp_type       entry_ff [DEPTH];
   logic [PtrWidth-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]   count_ff, count_in;
   logic                    do_push;
   logic                    do_pop;

   assign full      = (count_ff == CountWidth'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### sv/wpsp_back.sv
// ----------------------------------------------------------------------------
// wpsp_back
// Output register stage that drives the result channel.
// ----------------------------------------------------------------------------
module wpsp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  wpsp_pkg::rsp_type pop_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output wpsp_pkg::rsp_type rsp
);

   logic              rsp_valid_ff, rsp_valid_in;
   wpsp_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic              load;

   assign load      = !rsp_valid_ff || !rsp_stall;
   assign pop_ready = load;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_data_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_valid_in = pop_valid;
         if (pop_valid) begin
            rsp_data_in = pop_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule
